>>> hdl/gma_pkg.sv
// Package for the Gram matrix accumulator: shared widths, row and control
// types, and the saturating add used by every cell.
// No dependencies.
package gma_pkg;

  localparam int unsigned MaxCols  = 8;
  localparam int unsigned ElemW    = 16;
  localparam int unsigned ProdW    = 2 * ElemW;
  localparam int unsigned AccW     = 52;
  localparam int unsigned ColW     = 3;
  localparam int unsigned CountW   = 4;
  localparam int unsigned RidgeW   = 16;
  localparam int unsigned CfgIdxW  = 2;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegColumns = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRidge   = 2'd1;

  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  typedef logic [MaxCols-1:0][ElemW-1:0] row_t;
  typedef logic [ColW-1:0]               col_t;
  typedef logic [AccW-1:0]               acc_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic [CountW-1:0] n_cols;
    logic              ridge;
    logic [RidgeW-1:0] ridge_val;
    logic              clear;
  } cell_ctrl_t;

  // Add with saturation at the accumulator maximum
  function automatic acc_t sat_add(acc_t a, acc_t b);
    logic [AccW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AccW] ? AccMax : s[AccW-1:0];
  endfunction

endpackage

>>> hdl/gram_matrix_accumulate_core.sv
// Gram matrix accumulator top level: a chain of row cells that sum the
// outer product of each row, then stream out the matrix with ridge added.
// Depends on gma_pkg and gma_cell.
//
//   channel | handshake              | beat contents
//   --------+------------------------+-----------------------------------
//   in      | in_valid_i / in_stall_o| elem_a_i..elem_h_i, final_row_i
//   out     | out_valid_o/out_stall_i| out_row_o, out_col_o, entry_value_o,
//           |                        | last_entry_o
//   cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Rows that are not final are taken one per cycle; the row travels the
// eight cells one per cycle. After a final row the input stalls while the
// chain drains, then the ridge is added (StRidge), the first entry is
// loaded, and n*n entries leave at one per cycle, paced by out_stall_i.
// The store clears with the last entry, and the input opens again in the
// next cycle. Reset zeroes the store and sets columns to 8, ridge to 43.
module gram_matrix_accumulate_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [gma_pkg::ElemW-1:0]      elem_a_i,
  input  logic [gma_pkg::ElemW-1:0]      elem_b_i,
  input  logic [gma_pkg::ElemW-1:0]      elem_c_i,
  input  logic [gma_pkg::ElemW-1:0]      elem_d_i,
  input  logic [gma_pkg::ElemW-1:0]      elem_e_i,
  input  logic [gma_pkg::ElemW-1:0]      elem_f_i,
  input  logic [gma_pkg::ElemW-1:0]      elem_g_i,
  input  logic [gma_pkg::ElemW-1:0]      elem_h_i,
  input  logic                           final_row_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gma_pkg::ColW-1:0]       out_row_o,
  output logic [gma_pkg::ColW-1:0]       out_col_o,
  output logic [gma_pkg::AccW-1:0]       entry_value_o,
  output logic                           last_entry_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gma_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [gma_pkg::RidgeW-1:0]     cfg_data_i
);
  import gma_pkg::*;

  localparam logic [1:0] StAcc   = 2'd0;
  localparam logic [1:0] StDrain = 2'd1;
  localparam logic [1:0] StRidge = 2'd2;
  localparam logic [1:0] StEmit  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CountW-1:0] cols_q;
  logic [RidgeW-1:0] ridge_q;
  logic [CountW-1:0] n_cols;
  col_t              nm1;

  row_t              chain_row [MaxCols+1];
  logic              chain_vld [MaxCols+1];
  acc_t              cell_data [MaxCols];
  logic [MaxCols-1:0] cell_busy;
  cell_ctrl_t        ctrl;

  logic              in_acc;
  logic              out_vld_q, out_vld_d;
  col_t              out_row_q, out_row_d, out_col_q, out_col_d;
  acc_t              out_val_q, out_val_d;
  logic              out_last_q, out_last_d;
  col_t              nxt_r, nxt_c, rd_lo, rd_hi;
  logic              clear;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= CountW'(8);
      ridge_q <= RidgeW'(43);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegColumns) cols_q  <= cfg_data_i[CountW-1:0];
      if (cfg_index_i == RegRidge)   ridge_q <= cfg_data_i;
    end
  end

  // Clamp the column count to 1..MaxCols
  always_comb begin
    priority if (cols_q == '0) n_cols = CountW'(1);
    else if (cols_q > CountW'(MaxCols)) n_cols = CountW'(MaxCols);
    else n_cols = cols_q;
  end
  assign nm1 = ColW'(n_cols - CountW'(1));

  assign in_stall_o = (state_q != StAcc);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Feed the chain
  assign chain_row[0] = {elem_h_i, elem_g_i, elem_f_i, elem_e_i,
                         elem_d_i, elem_c_i, elem_b_i, elem_a_i};
  assign chain_vld[0] = in_acc;

  assign ctrl.n_cols    = n_cols;
  assign ctrl.ridge     = (state_q == StRidge);
  assign ctrl.ridge_val = ridge_q;
  assign ctrl.clear     = clear;

  for (genvar r = 0; r < MaxCols; r++) begin : g_cell
    gma_cell #(.ROW(r)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .row_i       (chain_row[r]),
      .row_valid_i (chain_vld[r]),
      .ctrl_i      (ctrl),
      .rd_col_i    (rd_hi),
      .row_o       (chain_row[r+1]),
      .row_valid_o (chain_vld[r+1]),
      .rd_data_o   (cell_data[r]),
      .busy_o      (cell_busy[r])
    );
  end

  // Next entry to present
  always_comb begin
    if (!out_vld_q) begin
      nxt_r = '0;
      nxt_c = '0;
    end else if (out_col_q == nm1) begin
      nxt_r = out_row_q + ColW'(1);
      nxt_c = '0;
    end else begin
      nxt_r = out_row_q;
      nxt_c = out_col_q + ColW'(1);
    end
    rd_lo = (nxt_r <= nxt_c) ? nxt_r : nxt_c;
    rd_hi = (nxt_r <= nxt_c) ? nxt_c : nxt_r;
  end

  // Sequence drain, ridge and readout
  always_comb begin
    state_d    = state_q;
    out_vld_d  = out_vld_q;
    out_row_d  = out_row_q;
    out_col_d  = out_col_q;
    out_val_d  = out_val_q;
    out_last_d = out_last_q;
    clear      = 1'b0;
    unique case (state_q)
      StAcc: begin
        if (in_acc && final_row_i) state_d = StDrain;
      end
      StDrain: begin
        if (cell_busy == '0) state_d = StRidge;
      end
      StRidge: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (!out_vld_q || !out_stall_i) begin
          if (out_vld_q && out_last_q) begin
            out_vld_d = 1'b0;
            clear     = 1'b1;
            state_d   = StAcc;
          end else begin
            out_vld_d  = 1'b1;
            out_row_d  = nxt_r;
            out_col_d  = nxt_c;
            out_val_d  = cell_data[rd_lo];
            out_last_d = (nxt_r == nm1) && (nxt_c == nm1);
          end
        end
      end
      default: state_d = StAcc;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StAcc;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_vld_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign entry_value_o = out_val_q;
  assign last_entry_o  = out_last_q;

endmodule

>>> hdl/gma_cell.sv
// One cell of the accumulator chain: owns row ROW of the upper triangle,
// multiplies its element by the row, accumulates, and passes the row on.
// Depends on gma_pkg.
module gma_cell #(
  parameter int unsigned ROW = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gma_pkg::row_t         row_i,
  input  logic                  row_valid_i,
  input  gma_pkg::cell_ctrl_t   ctrl_i,
  input  gma_pkg::col_t         rd_col_i,
  output gma_pkg::row_t         row_o,
  output logic                  row_valid_o,
  output gma_pkg::acc_t         rd_data_o,
  output logic                  busy_o
);
  import gma_pkg::*;

  row_t             row_q;
  logic             vld_q;
  logic [ProdW-1:0] prod_q [MaxCols];
  logic             pvld_q;
  acc_t             acc_q  [MaxCols];

  // Register the row, then hand it to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      pvld_q <= 1'b0;
    end else begin
      vld_q  <= row_valid_i;
      pvld_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_i;
  end

  // Form the products of this row's element with every column
  for (genvar c = 0; c < MaxCols; c++) begin : g_col
    logic upd;
    assign upd = (c >= ROW) && (CountW'(c) < ctrl_i.n_cols);

    always_ff @(posedge clk_i) begin
      prod_q[c] <= row_q[ROW] * row_q[c];
    end

    // Accumulate, add ridge on the diagonal, clear after readout
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_q[c] <= '0;
      end else if (ctrl_i.clear) begin
        acc_q[c] <= '0;
      end else if (pvld_q && upd) begin
        acc_q[c] <= sat_add(acc_q[c], AccW'(prod_q[c]));
      end else if (ctrl_i.ridge && (c == ROW) && upd) begin
        acc_q[c] <= sat_add(acc_q[c], AccW'(ctrl_i.ridge_val));
      end
    end
  end

  assign row_o       = row_q;
  assign row_valid_o = vld_q;
  assign rd_data_o   = acc_q[rd_col_i];
  assign busy_o      = vld_q | pvld_q;

endmodule

>>> tb/gram_matrix_accumulate_core_tb.sv
// Testbench for gram_matrix_accumulate_core: drives matrix rows, predicts the
// emitted Gram entries with a local accumulator model and checks each beat.
// Depends on gma_pkg and the RTL of gram_matrix_accumulate_core.
`timescale 1ns / 100ps

module gram_matrix_accumulate_core_tb;
  import gma_pkg::*;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [51:0] value;
    logic        last;
  } entry_t;

  typedef struct {
    logic [15:0] el [8];
    logic        fin;
    logic        has_exp;
    logic [51:0] exp00;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] elem_i [8];
  logic final_row_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] out_row_o, out_col_o;
  logic [51:0] entry_value_o;
  logic last_entry_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = RegColumns;
  logic [RidgeW-1:0] cfg_data_i = '0;

  // Predictor state
  logic [51:0] gram_acc [36];
  logic [3:0]  cols_reg;
  logic [15:0] ridge_reg;
  entry_t      pending_entries [$];
  logic [51:0] first_diag_q [$];

  int  errors = 0;
  int  cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;

  always #5 clk_i = ~clk_i;

  gram_matrix_accumulate_core uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .elem_a_i(elem_i[0]), .elem_b_i(elem_i[1]), .elem_c_i(elem_i[2]),
    .elem_d_i(elem_i[3]), .elem_e_i(elem_i[4]), .elem_f_i(elem_i[5]),
    .elem_g_i(elem_i[6]), .elem_h_i(elem_i[7]), .final_row_i,
    .out_valid_o, .out_stall_i, .out_row_o, .out_col_o, .entry_value_o,
    .last_entry_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  function automatic int tri_pos(int r, int c);
    return r * 8 - (r * (r > 0 ? r - 1 : 0)) / 2 + (c - r);
  endfunction

  function automatic logic [51:0] acc_sat(logic [51:0] a, logic [51:0] b);
    logic [52:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[52] ? {52{1'b1}} : s[51:0];
  endfunction

  // Fold one row into the store; on the final row add the ridge, queue the full matrix and clear the store
  task automatic predict_row(stim_t s);
    int n, k;
    n = (cols_reg == 0) ? 1 : (cols_reg > 8 ? 8 : int'(cols_reg));
    for (int i = 0; i < n; i++)
      for (int j = i; j < n; j++) begin
        k = tri_pos(i, j);
        gram_acc[k] = acc_sat(gram_acc[k], 52'(s.el[i]) * 52'(s.el[j]));
      end
    if (s.fin) begin
      for (int i = 0; i < n; i++) gram_acc[tri_pos(i, i)] =
          acc_sat(gram_acc[tri_pos(i, i)], 52'(ridge_reg));
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          pending_entries.push_back('{3'(i), 3'(j),
              gram_acc[i <= j ? tri_pos(i, j) : tri_pos(j, i)],
              (i == n - 1 && j == n - 1)});
      if (s.has_exp) first_diag_q.push_back(s.exp00);
      foreach (gram_acc[k2]) gram_acc[k2] = '0;
    end
  endtask

  // Check every accepted output beat
  always @(posedge clk_i) begin
    entry_t exp_e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected beat row %0d col %0d value %0h", $realtime,
                 out_row_o, out_col_o, entry_value_o);
        errors++;
      end else begin
        exp_e = pending_entries.pop_front();
        if (exp_e.row !== out_row_o || exp_e.col !== out_col_o ||
            exp_e.value !== entry_value_o || exp_e.last !== last_entry_o) begin
          $display("%0t: expected r%0d c%0d v%0h l%0b, actual r%0d c%0d v%0h l%0b",
                   $realtime, exp_e.row, exp_e.col, exp_e.value, exp_e.last,
                   out_row_o, out_col_o, entry_value_o, last_entry_o);
          errors++;
        end
        if (out_row_o == 0 && out_col_o == 0 && first_diag_q.size() > 0) begin
          if (first_diag_q[0] !== entry_value_o) begin
            $display("%0t: expected entry(0,0) %0h, actual %0h", $realtime,
                     first_diag_q[0], entry_value_o);
            errors++;
          end
          void'(first_diag_q.pop_front());
        end
      end
    end
  end

  // Receiver stall pattern
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegColumns) cols_reg = val[3:0];
    else ridge_reg = val;
  endtask

  // Drive one row beat, with random sender gaps
  task automatic send_row(stim_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int i = 0; i < 8; i++) elem_i[i] <= s.el[i];
    final_row_i <= s.fin;
    do @(posedge clk_i); while (in_stall_o);
    predict_row(s);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_entries.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic stim_t rand_row(bit fin);
    stim_t s;
    int mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 8; i++)
      s.el[i] = (mode == 0) ? 16'hFFFF : (mode == 1) ? 16'(0) : 16'($urandom);
    s.fin = fin;
    s.has_exp = 1'b0;
    s.exp00 = '0;
    return s;
  endfunction

  stim_t directed [$];
  stim_t s;
  int sent;
  int mat_len;

  initial begin
    for (int i = 0; i < 8; i++) elem_i[i] = '0;
    foreach (gram_acc[k]) gram_acc[k] = '0;
    cols_reg = 4'd8;
    ridge_reg = 16'd43;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: after reset, zeros, full scale, several full-scale rows, a random row
    s = rand_row(1'b1);
    foreach (s.el[i]) s.el[i] = '0;
    s.has_exp = 1'b1; s.exp00 = 52'd43;
    directed.push_back(s);
    foreach (s.el[i]) s.el[i] = 16'hFFFF;
    s.exp00 = 52'hFFFE0001 + 52'd43;
    directed.push_back(s);
    s.has_exp = 1'b0; s.fin = 1'b0;
    for (int r = 0; r < 4; r++) directed.push_back(s);
    s.fin = 1'b1;
    directed.push_back(s);
    s = rand_row(1'b1);
    directed.push_back(s);
    foreach (directed[d]) send_row(directed[d]);
    drain();

    // Column extremes and out-of-range counts, ridge extremes
    write_reg(RegColumns, 16'd0);
    write_reg(RegRidge, 16'hFFFF);
    s = rand_row(1'b0); send_row(s);
    s = rand_row(1'b1); send_row(s);
    drain();
    write_reg(RegColumns, 16'd15);
    write_reg(RegRidge, 16'd0);
    s = rand_row(1'b1); send_row(s);
    drain();
    write_reg(RegColumns, 16'd1);
    s = rand_row(1'b1); send_row(s);
    drain();

    // Full scale: nine full-scale rows in two columns, below the 2^52 limit
    write_reg(RegColumns, 16'd2);
    s = rand_row(1'b0);
    foreach (s.el[i]) s.el[i] = 16'hFFFF;
    for (int r = 0; r < 8; r++) send_row(s);
    s.fin = 1'b1; send_row(s);
    drain();

    // Random phases with varying idle patterns and settings
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      write_reg(RegColumns, 16'($urandom_range(15)));
      write_reg(RegRidge, 16'($urandom));
      for (int m = 0; m < 12 && sent < 290; m++) begin
        mat_len = $urandom_range(5);
        for (int r = 0; r < mat_len; r++) begin
          send_row(rand_row(1'b0));
          sent++;
        end
        send_row(rand_row(1'b1));
        sent++;
        // Occasionally change the column count between matrices
        if ($urandom_range(9) == 0) begin
          drain();
          write_reg(RegColumns, 16'($urandom_range(1, 8)));
        end
      end
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();

    if (errors == 0 && pending_entries.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
